// ===== src/bitok_pkg.sv =====
`default_nettype none

package bitok_pkg;

    localparam int unsigned OFFSET_BITS_DEF = 32;
    localparam int unsigned COLUMN_BITS_DEF = 16;
    localparam int unsigned LINE_BITS_DEF   = 24;

    // Results one source byte can cause: closed run, next token, end marker
    localparam int unsigned MAX_TOKENS = 3;
    localparam int unsigned SLOT_BITS  = $clog2(MAX_TOKENS + 1);

    typedef enum logic [2:0] {
        KIND_LBRACKET = 3'd0,
        KIND_RBRACKET = 3'd1,
        KIND_LPAREN   = 3'd2,
        KIND_RPAREN   = 3'd3,
        KIND_INT      = 3'd4,
        KIND_IDENT    = 3'd5,
        KIND_UNKNOWN  = 3'd6,
        KIND_END      = 3'd7
    } t_kind;

    localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
    localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
    localparam logic [7:0] CHAR_LPAREN   = 8'h28;
    localparam logic [7:0] CHAR_RPAREN   = 8'h29;
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_UNDER    = 8'h5F;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_VTAB     = 8'h0B;
    localparam logic [7:0] CHAR_FFEED    = 8'h0C;
    localparam logic [7:0] CHAR_CRET     = 8'h0D;

    typedef struct packed {
        logic  is_digit;
        logic  is_alpha;
        logic  is_under;
        logic  is_newline;
        logic  is_blank;
        t_kind single_kind;
    } t_byte_class;

    typedef struct packed {
        logic                 load;
        logic [SLOT_BITS-1:0] count;
    } t_grp_ctl;

endpackage

`default_nettype wire

// ===== src/bitok_class.sv =====
`default_nettype none

module bitok_class (
    input  wire logic [7:0]           i_byte,
    output bitok_pkg::t_byte_class    o_class
);
    import bitok_pkg::*;

    always_comb begin
        o_class.is_digit   = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        o_class.is_alpha   = ((i_byte >= 8'h41) && (i_byte <= 8'h5A))
                          || ((i_byte >= 8'h61) && (i_byte <= 8'h7A));
        o_class.is_under   = (i_byte == CHAR_UNDER);
        o_class.is_newline = (i_byte == CHAR_NEWLINE);
        o_class.is_blank   = (i_byte == CHAR_SPACE) || (i_byte == CHAR_TAB)
                          || (i_byte == CHAR_VTAB) || (i_byte == CHAR_FFEED)
                          || (i_byte == CHAR_CRET);
        case (i_byte)
            CHAR_LBRACKET: o_class.single_kind = KIND_LBRACKET;
            CHAR_RBRACKET: o_class.single_kind = KIND_RBRACKET;
            CHAR_LPAREN:   o_class.single_kind = KIND_LPAREN;
            CHAR_RPAREN:   o_class.single_kind = KIND_RPAREN;
            default:       o_class.single_kind = KIND_UNKNOWN;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/bitok_core.sv =====
`default_nettype none

module bitok_core #(
    parameter int unsigned OFFSET_BITS = bitok_pkg::OFFSET_BITS_DEF,
    parameter int unsigned COLUMN_BITS = bitok_pkg::COLUMN_BITS_DEF,
    parameter int unsigned LINE_BITS   = bitok_pkg::LINE_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [7:0]                             i_source_byte,
    input  wire logic                                   i_final_byte,
    input  wire logic                                   i_grp_free,
    output bitok_pkg::t_grp_ctl                         o_grp_ctl,
    output bitok_pkg::t_kind [bitok_pkg::MAX_TOKENS-1:0] o_kind,
    output logic [bitok_pkg::MAX_TOKENS-1:0][OFFSET_BITS-1:0] o_start_offset,
    output logic [bitok_pkg::MAX_TOKENS-1:0][OFFSET_BITS-1:0] o_end_offset,
    output logic [bitok_pkg::MAX_TOKENS-1:0][COLUMN_BITS-1:0] o_start_column,
    output logic [bitok_pkg::MAX_TOKENS-1:0][COLUMN_BITS-1:0] o_end_column,
    output logic [bitok_pkg::MAX_TOKENS-1:0][LINE_BITS-1:0]   o_line_number
);
    import bitok_pkg::*;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_INT   = 2'd1,
        MODE_IDENT = 2'd2
    } t_mode;

    typedef struct packed {
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] so;
        logic [OFFSET_BITS-1:0] eo;
        logic [COLUMN_BITS-1:0] sc;
        logic [COLUMN_BITS-1:0] ec;
        logic [LINE_BITS-1:0]   ln;
    } t_tok;

    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_final;

    // Scan state
    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [OFFSET_BITS-1:0] r_rso, n_rso;
    logic [COLUMN_BITS-1:0] r_rsc, n_rsc;

    t_byte_class cls;
    logic        consume;
    logic        is_open, cont, word;
    logic        has_a, has_b, has_c, has_d;
    logic [OFFSET_BITS-1:0] off1;
    logic [COLUMN_BITS-1:0] col1;
    t_mode                  m_mode;
    logic [OFFSET_BITS-1:0] m_off;
    logic [COLUMN_BITS-1:0] m_col;
    logic [LINE_BITS-1:0]   m_line;
    logic [OFFSET_BITS-1:0] m_rso;
    logic [COLUMN_BITS-1:0] m_rsc;
    t_tok                   tok_a, tok_b, tok_c, tok_d;
    t_tok [MAX_TOKENS-1:0]  slot;
    logic [SLOT_BITS-1:0]   pos_c, pos_d, count;

    bitok_class u_class (
        .i_byte  (r_byte),
        .o_class (cls)
    );

    always_comb begin
        is_open = (r_mode == MODE_INT) || (r_mode == MODE_IDENT);
        cont    = ((r_mode == MODE_INT) && cls.is_digit)
               || ((r_mode == MODE_IDENT)
                   && (cls.is_digit || cls.is_alpha || cls.is_under));
        word    = cls.is_digit || cls.is_alpha || cls.is_under;
        off1    = r_off + OFFSET_BITS'(1);
        col1    = r_col + COL_ONE;

        m_mode = r_mode;
        m_off  = off1;
        m_col  = col1;
        m_line = r_line;
        m_rso  = r_rso;
        m_rsc  = r_rsc;
        if (!cont) begin
            m_mode = MODE_NONE;
            if (cls.is_newline) begin
                m_col = COL_ONE;
                if (r_line != {LINE_BITS{1'b1}}) begin
                    m_line = r_line + LINE_ONE;
                end
            end else if (!cls.is_blank && word) begin
                m_mode = cls.is_digit ? MODE_INT : MODE_IDENT;
                m_rso  = r_off;
                m_rsc  = r_col;
            end
        end

        // Candidate tokens in emission order
        has_a = is_open && !cont;
        has_b = !cont && !cls.is_newline && !cls.is_blank && !word;
        has_c = r_final && ((m_mode == MODE_INT) || (m_mode == MODE_IDENT));
        has_d = r_final;

        tok_a = '{kind: (r_mode == MODE_INT) ? KIND_INT : KIND_IDENT,
                  so: r_rso, eo: r_off, sc: r_rsc, ec: r_col, ln: r_line};
        tok_b = '{kind: cls.single_kind,
                  so: r_off, eo: off1, sc: r_col, ec: col1, ln: r_line};
        tok_c = '{kind: (m_mode == MODE_INT) ? KIND_INT : KIND_IDENT,
                  so: m_rso, eo: m_off, sc: m_rsc, ec: m_col, ln: m_line};
        tok_d = '{kind: KIND_END,
                  so: m_off, eo: m_off, sc: m_col, ec: m_col, ln: m_line};

        pos_c = SLOT_BITS'(has_a) + SLOT_BITS'(has_b);
        pos_d = pos_c + SLOT_BITS'(has_c);
        count = pos_d + SLOT_BITS'(has_d);

        for (int j = 0; j < MAX_TOKENS; j++) begin
            if (has_a && (j == 0)) begin
                slot[j] = tok_a;
            end else if (has_b && (SLOT_BITS'(has_a) == SLOT_BITS'(j))) begin
                slot[j] = tok_b;
            end else if (has_c && (pos_c == SLOT_BITS'(j))) begin
                slot[j] = tok_c;
            end else begin
                slot[j] = tok_d;
            end
        end

        consume = r_in_valid && ((count == '0) || i_grp_free);

        if (r_final) begin
            n_mode = MODE_NONE;
            n_off  = '0;
            n_col  = COL_ONE;
            n_line = LINE_ONE;
            n_rso  = '0;
            n_rsc  = COL_ONE;
        end else begin
            n_mode = m_mode;
            n_off  = m_off;
            n_col  = m_col;
            n_line = m_line;
            n_rso  = m_rso;
            n_rsc  = m_rsc;
        end
    end

    assign o_in_ready      = !r_in_valid || consume;
    assign o_grp_ctl.load  = r_in_valid && (count != '0) && i_grp_free;
    assign o_grp_ctl.count = count;

    always_comb begin
        for (int j = 0; j < MAX_TOKENS; j++) begin
            o_kind[j]         = slot[j].kind;
            o_start_offset[j] = slot[j].so;
            o_end_offset[j]   = slot[j].eo;
            o_start_column[j] = slot[j].sc;
            o_end_column[j]   = slot[j].ec;
            o_line_number[j]  = slot[j].ln;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_NONE;
            r_off      <= '0;
            r_col      <= COL_ONE;
            r_line     <= LINE_ONE;
            r_rso      <= '0;
            r_rsc      <= COL_ONE;
        end else begin
            if (consume) begin
                r_mode <= n_mode;
                r_off  <= n_off;
                r_col  <= n_col;
                r_line <= n_line;
                r_rso  <= n_rso;
                r_rsc  <= n_rsc;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte  <= i_source_byte;
            r_final <= i_final_byte;
        end
    end

endmodule

`default_nettype wire

// ===== src/bracket_ident_int_tokenizer_top.sv =====
`default_nettype none

// Byte-serial tokenizer: one source byte per request, final_byte set on the
// last byte of the source. Integers, identifiers, brackets, parentheses and
// unknown bytes come out as tokens with start/end offset, column and line;
// the final byte flushes any open run and adds an end marker, then the scan
// state returns to its reset value for the next source. A byte is accepted
// every cycle while the result side keeps up; a byte with no token never
// waits for the result register, and a byte with N tokens (up to three)
// holds that register until all N have left, one per cycle while the output
// is ready. The input register in front of the step logic takes a new byte
// while earlier tokens drain; tokens pass it, then the result register.
module bracket_ident_int_tokenizer_top #(
    parameter int unsigned OFFSET_BITS = bitok_pkg::OFFSET_BITS_DEF,
    parameter int unsigned COLUMN_BITS = bitok_pkg::COLUMN_BITS_DEF,
    parameter int unsigned LINE_BITS   = bitok_pkg::LINE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [7:0]             i_source_byte,
    input  wire logic                   i_final_byte,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [2:0]                  o_token_kind,
    output logic [OFFSET_BITS-1:0]      o_start_offset,
    output logic [OFFSET_BITS-1:0]      o_end_offset,
    output logic [COLUMN_BITS-1:0]      o_start_column,
    output logic [COLUMN_BITS-1:0]      o_end_column,
    output logic [LINE_BITS-1:0]        o_line_number,
    output logic                        o_last_of_run
);
    import bitok_pkg::*;

    t_grp_ctl                               grp_ctl;
    logic                                   grp_free;
    logic                                   drain_last;
    t_kind [MAX_TOKENS-1:0]                 c_kind;
    logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0] c_so, c_eo;
    logic [MAX_TOKENS-1:0][COLUMN_BITS-1:0] c_sc, c_ec;
    logic [MAX_TOKENS-1:0][LINE_BITS-1:0]   c_ln;

    // Result group register
    logic                                   r_grp_valid;
    logic [SLOT_BITS-1:0]                   r_idx;
    logic [SLOT_BITS-1:0]                   r_cnt;
    t_kind [MAX_TOKENS-1:0]                 r_kind;
    logic [MAX_TOKENS-1:0][OFFSET_BITS-1:0] r_so, r_eo;
    logic [MAX_TOKENS-1:0][COLUMN_BITS-1:0] r_sc, r_ec;
    logic [MAX_TOKENS-1:0][LINE_BITS-1:0]   r_ln;

    bitok_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_source_byte  (i_source_byte),
        .i_final_byte   (i_final_byte),
        .i_grp_free     (grp_free),
        .o_grp_ctl      (grp_ctl),
        .o_kind         (c_kind),
        .o_start_offset (c_so),
        .o_end_offset   (c_eo),
        .o_start_column (c_sc),
        .o_end_column   (c_ec),
        .o_line_number  (c_ln)
    );

    assign drain_last = (r_idx == (r_cnt - SLOT_BITS'(1)));
    assign grp_free   = !r_grp_valid || (i_out_ready && drain_last);

    assign o_out_valid    = r_grp_valid;
    assign o_token_kind   = r_kind[r_idx[1:0]];
    assign o_start_offset = r_so[r_idx[1:0]];
    assign o_end_offset   = r_eo[r_idx[1:0]];
    assign o_start_column = r_sc[r_idx[1:0]];
    assign o_end_column   = r_ec[r_idx[1:0]];
    assign o_line_number  = r_ln[r_idx[1:0]];
    assign o_last_of_run  = drain_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
        end else if (grp_ctl.load) begin
            r_grp_valid <= 1'b1;
            r_idx       <= '0;
            r_cnt       <= grp_ctl.count;
        end else if (r_grp_valid && i_out_ready) begin
            // advance to the next token, drop the group after its last
            if (drain_last) begin
                r_grp_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + SLOT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (grp_ctl.load) begin
            r_kind <= c_kind;
            r_so   <= c_so;
            r_eo   <= c_eo;
            r_sc   <= c_sc;
            r_ec   <= c_ec;
            r_ln   <= c_ln;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_bracket_ident_int_tokenizer_top.sv =====
`timescale 1ns / 100ps

module tb_bracket_ident_int_tokenizer_top;
    import bitok_pkg::*;

    localparam int unsigned OFF_W          = OFFSET_BITS_DEF;
    localparam int unsigned COL_W          = COLUMN_BITS_DEF;
    localparam int unsigned LINE_W         = LINE_BITS_DEF;
    localparam int unsigned IDLE_PCT       = 32;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned RANDOM_BYTES   = 435;
    localparam int unsigned DRAIN_CYCLES   = 10;

    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_HASH    = 8'h23;

    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_INT   = 2'd1,
        RUN_IDENT = 2'd2
    } t_run;

    typedef struct packed {
        t_kind              kind;
        logic [OFF_W-1:0]   start_off;
        logic [OFF_W-1:0]   end_off;
        logic [COL_W-1:0]   first_col;
        logic [COL_W-1:0]   end_col;
        logic [LINE_W-1:0]  line_no;
        logic               last;
    } t_token;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic [7:0]         i_source_byte = 8'h00;
    logic               i_final_byte  = 1'b0;
    logic               i_out_ready   = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [2:0]         o_token_kind;
    logic [OFF_W-1:0]   o_start_offset;
    logic [OFF_W-1:0]   o_end_offset;
    logic [COL_W-1:0]   o_start_column;
    logic [COL_W-1:0]   o_end_column;
    logic [LINE_W-1:0]  o_line_number;
    logic               o_last_of_run;

    // Scan state of the predictor
    t_run               scan_mode;
    logic [OFF_W-1:0]   scan_off;
    logic [COL_W-1:0]   scan_col;
    logic [LINE_W-1:0]  scan_line;
    logic [OFF_W-1:0]   run_off;
    logic [COL_W-1:0]   run_col;

    t_token             expected_tokens[$];
    bit                 in_gaps        = 1'b1;
    bit                 out_stalls     = 1'b1;
    int                 error_count    = 0;
    int                 tokens_checked = 0;
    int                 bytes_sent     = 0;
    int                 sources_sent   = 0;
    int                 idle_cycles    = 0;

    bracket_ident_int_tokenizer_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_source_byte  (i_source_byte),
        .i_final_byte   (i_final_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_end_offset   (o_end_offset),
        .o_start_column (o_start_column),
        .o_end_column   (o_end_column),
        .o_line_number  (o_line_number),
        .o_last_of_run  (o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9;
    endfunction

    function automatic bit is_word(input logic [7:0] c);
        return is_digit(c) || c == CHAR_UNDER ||
               (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c inside {CHAR_SPACE, CHAR_TAB, CHAR_VTAB, CHAR_FFEED, CHAR_CRET};
    endfunction

    function automatic void reset_scan();
        scan_mode = RUN_NONE;
        scan_off  = '0;
        scan_col  = COL_W'(1);
        scan_line = LINE_W'(1);
        run_off   = '0;
        run_col   = COL_W'(1);
    endfunction

    function automatic void step_pos();
        scan_off = scan_off + 1'b1;
        scan_col = scan_col + 1'b1;
    endfunction

    function automatic t_token make_tok(input t_kind kind,
                                        input logic [OFF_W-1:0] so,
                                        input logic [OFF_W-1:0] eo,
                                        input logic [COL_W-1:0] sc,
                                        input logic [COL_W-1:0] ec);
        t_token tok;
        tok.kind      = kind;
        tok.start_off = so;
        tok.end_off   = eo;
        tok.first_col = sc;
        tok.end_col   = ec;
        tok.line_no   = scan_line;
        tok.last      = 1'b0;
        return tok;
    endfunction

    function automatic void close_run();
        expected_tokens.push_back(make_tok(scan_mode == RUN_INT ? KIND_INT : KIND_IDENT,
                                           run_off, scan_off, run_col, scan_col));
        scan_mode = RUN_NONE;
    endfunction

    // Work out the tokens one accepted source byte causes and queue them
    function automatic void tokenize_byte(input logic [7:0] c, input logic is_final);
        int    n;
        t_kind kind;
        n = 0;
        if ((scan_mode == RUN_INT && is_digit(c)) ||
            (scan_mode == RUN_IDENT && is_word(c))) begin
            step_pos();
        end else begin
            if (scan_mode != RUN_NONE) begin
                close_run();
                n++;
            end
            if (c == CHAR_NEWLINE) begin
                scan_col = COL_W'(1);
                if (scan_line != '1)
                    scan_line = scan_line + 1'b1;
                scan_off = scan_off + 1'b1;
            end else if (is_blank(c)) begin
                step_pos();
            end else if (is_word(c)) begin
                scan_mode = is_digit(c) ? RUN_INT : RUN_IDENT;
                run_off   = scan_off;
                run_col   = scan_col;
                step_pos();
            end else begin
                case (c)
                    CHAR_LBRACKET: kind = KIND_LBRACKET;
                    CHAR_RBRACKET: kind = KIND_RBRACKET;
                    CHAR_LPAREN:   kind = KIND_LPAREN;
                    CHAR_RPAREN:   kind = KIND_RPAREN;
                    default:       kind = KIND_UNKNOWN;
                endcase
                expected_tokens.push_back(make_tok(kind, scan_off, scan_off + 1'b1,
                                                   scan_col, scan_col + 1'b1));
                n++;
                step_pos();
            end
        end
        if (is_final) begin
            if (scan_mode != RUN_NONE) begin
                close_run();
                n++;
            end
            expected_tokens.push_back(make_tok(KIND_END, scan_off, scan_off,
                                               scan_col, scan_col));
            n++;
            reset_scan();
        end
        if (n > 0)
            expected_tokens[$].last = 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic is_final);
        while (in_gaps && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_source_byte <= c;
        i_final_byte  <= is_final;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        tokenize_byte(c, is_final);
        bytes_sent++;
        if (is_final)
            sources_sent++;
    endtask

    task automatic send_text(input string s, input bit close_source);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], close_source && i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_byte();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 18)
            return 8'(CHAR_LOWER_A + $urandom_range(25));
        if (roll < 26)
            return 8'(CHAR_UPPER_A + $urandom_range(25));
        if (roll < 30)
            return CHAR_UNDER;
        if (roll < 48)
            return 8'(CHAR_DIGIT_0 + $urandom_range(9));
        if (roll < 62) begin
            case ($urandom_range(3))
                0:       return CHAR_LBRACKET;
                1:       return CHAR_RBRACKET;
                2:       return CHAR_LPAREN;
                default: return CHAR_RPAREN;
            endcase
        end
        if (roll < 70)
            return CHAR_SPACE;
        if (roll < 74)
            return CHAR_NEWLINE;
        if (roll < 78) begin
            case ($urandom_range(3))
                0:       return CHAR_TAB;
                1:       return CHAR_VTAB;
                2:       return CHAR_FFEED;
                default: return CHAR_CRET;
            endcase
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic test_punctuation();
        send_text("[]()", 1'b0);
        send_byte(CHAR_HASH, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_runs();
        // identifier with underscore and digit, then an integer cut short by a letter
        send_text("_x9 12z", 1'b0);
    endtask

    task automatic test_blanks_and_final();
        send_byte(CHAR_TAB, 1'b0);
        send_byte(CHAR_VTAB, 1'b0);
        send_byte(CHAR_FFEED, 1'b0);
        send_byte(CHAR_CRET, 1'b0);
        send_byte(CHAR_NEWLINE, 1'b0);
        // open integer, a bracket and the end marker all from the final byte
        send_text("7(", 1'b1);
        send_text("Z", 1'b1);
        send_byte(CHAR_SPACE, 1'b1);
    endtask

    task automatic test_random_sources();
        int          counted;
        int unsigned len;
        logic [7:0]  c;
        counted = 0;
        while (counted < RANDOM_BYTES) begin
            // hold both sides busy for a stretch in the middle
            in_gaps    = !(counted >= 150 && counted < 250);
            out_stalls = in_gaps;
            len = $urandom_range(24, 1);
            for (int unsigned i = 0; i < len; i++) begin
                c = pick_byte();
                send_byte(c, i == len - 1);
                counted++;
            end
        end
        in_gaps    = 1'b1;
        out_stalls = 1'b1;
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_token exp_tok;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tokens.size() == 0) begin
                $error("token with nothing expected: kind %0d, start_offset %0d",
                       o_token_kind, o_start_offset);
                error_count++;
            end else begin
                exp_tok = expected_tokens.pop_front();
                check_field("token_kind", 64'(exp_tok.kind), 64'(o_token_kind));
                check_field("start_offset", 64'(exp_tok.start_off), 64'(o_start_offset));
                check_field("end_offset", 64'(exp_tok.end_off), 64'(o_end_offset));
                check_field("start_column", 64'(exp_tok.first_col), 64'(o_start_column));
                check_field("end_column", 64'(exp_tok.end_col), 64'(o_end_column));
                check_field("line_number", 64'(exp_tok.line_no), 64'(o_line_number));
                check_field("last_of_run", 64'(exp_tok.last), 64'(o_last_of_run));
                tokens_checked++;
            end
        end
        i_out_ready <= !out_stalls || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reset_scan();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_punctuation();
        test_runs();
        test_blanks_and_final();
        test_random_sources();

        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d sources and checked %0d tokens,", bytes_sent,
                 sources_sent, tokens_checked);
        $display("covering every token kind, all blanks, final-byte flushes and random text.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
